@@ rtl/bclwt_pkg.sv @@
// shared types and constants of the sector cache tag engine
package bclwt_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int SECTOR_BITS = 23;
    localparam int STAMP_BITS  = 32;
    localparam int IDX_BITS    = 6;
    localparam int COUNT_BITS  = 32;

    // request codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]             opcode;
        logic [SECTOR_BITS-1:0] sector;
        logic [STAMP_BITS-1:0]  now_tick;
    } t_in_item;

    typedef struct packed {
        logic [IDX_BITS-1:0]    slot;
        logic                   hit;
        logic                   fill_needed;
        logic                   writeback_needed;
        logic [SECTOR_BITS-1:0] writeback_sector;
        logic                   last;
        logic [COUNT_BITS-1:0]  call_count;
        logic [COUNT_BITS-1:0]  miss_count;
    } t_out_item;

    // one tag store word
    typedef struct packed {
        logic                   dirty;
        logic                   valid;
        logic [STAMP_BITS-1:0]  stamp;
        logic [SECTOR_BITS-1:0] sector;
    } t_entry;

endpackage

@@ rtl/bclwt_ram.sv @@
// generic simple dual port ram with registered read
module bclwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/block_cache_lru_writeback_tags.sv @@
// top level of the fully associative lru write-back sector cache tag engine
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// a read or write item is served by a scan, one ram read per entry through
// the single tag store with each registered read word checked, then by an
// update step that writes the entry and emits the result, waiting while the
// output stalls; the next item can be taken in the cycle after the update
// a flush reads, then rewrites each entry in turn, emitting its results and
// waiting while the output stalls; after reset a clearing pass writes every
// entry while the input stalls; one output register sits between the engine
// and the consumer, so a new item is taken while a result still waits
module block_cache_lru_writeback_tags
    import bclwt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // sequencer states
    localparam logic [2:0] ST_CLR  = 3'd0;  // clearing pass after reset
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;  // tag and stamp scan of a request
    localparam logic [2:0] ST_UPD  = 3'd3;  // write entry, emit result
    localparam logic [2:0] ST_FRD  = 3'd4;  // flush: read entry
    localparam logic [2:0] ST_FEV  = 3'd5;  // flush: evaluate and rewrite entry
    localparam logic [2:0] ST_FEND = 3'd6;  // flush: emit held result as last

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [IW-1:0]         r_idx;       // address being issued or swept
    logic                  r_issue_done;
    logic                  r_chk;       // read data of r_chk_idx is present
    logic [IW-1:0]         r_chk_idx;

    // request context
    logic                   r_wr;
    logic [SECTOR_BITS-1:0] r_sec;
    logic [STAMP_BITS-1:0]  r_now;

    // scan results
    logic                   r_found;
    logic [IW-1:0]          r_hit_idx;
    logic                   r_hit_dirty;
    logic [IW-1:0]          r_best_idx;
    logic [STAMP_BITS-1:0]  r_best_stamp;
    logic                   r_vic_wb;
    logic [SECTOR_BITS-1:0] r_vic_sector;

    // flush result held back until the next dirty entry or the end is known
    logic                   r_pend_valid;
    logic [IW-1:0]          r_pend_idx;
    logic [SECTOR_BITS-1:0] r_pend_sector;

    logic [COUNT_BITS-1:0]  r_calls;
    logic [COUNT_BITS-1:0]  r_misses;

    logic                   r_out_valid;
    t_out_item              r_out;

    // tag store port signals
    logic                   we;
    logic [IW-1:0]          waddr;
    t_entry                 wdata;
    logic                   re;
    logic [$bits(t_entry)-1:0] rdata_raw;
    t_entry                 rd;

    logic                   in_acc;
    logic                   out_free;
    logic                   emit;
    t_out_item              emit_data;
    logic                   match;
    logic                   older;
    logic                   fev_go;

    assign o_in_stall = !i_rst_n || (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign rd         = t_entry'(rdata_raw);

    // shared compare unit of the scan: tag equality and stamp order
    assign match = rd.valid && (rd.sector == r_sec);
    assign older = (r_chk_idx == '0) || (rd.stamp < r_best_stamp);

    // a flush step may proceed unless it has to push a held result and cannot
    assign fev_go = !rd.dirty || !r_pend_valid || out_free;

    bclwt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_idx),
        .o_rdata (rdata_raw)
    );

    always_comb begin
        n_state   = r_state;
        we        = 1'b0;
        waddr     = r_idx;
        wdata     = '0;
        re        = 1'b0;
        emit      = 1'b0;
        emit_data = '0;
        unique case (r_state)
            ST_CLR: begin
                we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    priority if (i_in_data.opcode == OP_READ ||
                                 i_in_data.opcode == OP_WRITE) begin
                        n_state = ST_SCAN;
                    end else if (i_in_data.opcode == OP_FLUSH) begin
                        n_state = ST_FRD;
                    end else begin
                        n_state = ST_IDLE;  // unused code: dropped
                    end
                end
            end
            ST_SCAN: begin
                re = !r_issue_done;
                if (r_chk && r_chk_idx == LAST_IDX) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    // hit and miss write the same record but for the dirty mark
                    we           = 1'b1;
                    waddr        = r_found ? r_hit_idx : r_best_idx;
                    wdata.dirty  = r_wr | (r_found & r_hit_dirty);
                    wdata.valid  = 1'b1;
                    wdata.stamp  = r_now;
                    wdata.sector = r_sec;
                    emit                       = 1'b1;
                    emit_data.slot             = IDX_BITS'(waddr);
                    emit_data.hit              = r_found;
                    emit_data.fill_needed      = !r_found;
                    emit_data.writeback_needed = !r_found && r_vic_wb;
                    emit_data.writeback_sector =
                        (!r_found && r_vic_wb) ? r_vic_sector : '0;
                    emit_data.last             = 1'b1;
                    emit_data.call_count       = r_calls + COUNT_BITS'(1);
                    emit_data.miss_count       = r_misses + COUNT_BITS'(!r_found);
                    n_state                    = ST_IDLE;
                end
            end
            ST_FRD: begin
                re      = 1'b1;
                n_state = ST_FEV;
            end
            ST_FEV: begin
                if (fev_go) begin
                    we           = 1'b1;
                    wdata.dirty  = 1'b0;
                    wdata.valid  = rd.valid;
                    wdata.stamp  = r_now;
                    wdata.sector = rd.sector;
                    if (rd.dirty && r_pend_valid) begin
                        emit                       = 1'b1;
                        emit_data.slot             = IDX_BITS'(r_pend_idx);
                        emit_data.writeback_needed = 1'b1;
                        emit_data.writeback_sector = r_pend_sector;
                        emit_data.last             = 1'b0;
                        emit_data.call_count       = r_calls;
                        emit_data.miss_count       = r_misses;
                    end
                    n_state = (r_idx == LAST_IDX) ? ST_FEND : ST_FRD;
                end
            end
            ST_FEND: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    emit                       = 1'b1;
                    emit_data.slot             = IDX_BITS'(r_pend_idx);
                    emit_data.writeback_needed = 1'b1;
                    emit_data.writeback_sector = r_pend_sector;
                    emit_data.last             = 1'b1;
                    emit_data.call_count       = r_calls;
                    emit_data.miss_count       = r_misses;
                    n_state                    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLR;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_chk        <= 1'b0;
            r_found      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_calls      <= '0;
            r_misses     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_CLR: begin
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + IW'(1);
                end
                ST_IDLE: begin
                    r_idx        <= '0;
                    r_issue_done <= 1'b0;
                    r_chk        <= 1'b0;
                    r_found      <= 1'b0;
                    r_pend_valid <= 1'b0;
                    if (in_acc && i_in_data.opcode == OP_FLUSH) begin
                        r_calls  <= '0;
                        r_misses <= '0;
                    end
                end
                ST_SCAN: begin
                    r_chk     <= !r_issue_done;
                    r_chk_idx <= r_idx;
                    if (!r_issue_done) begin
                        if (r_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                    if (r_chk && match && !r_found) begin
                        r_found <= 1'b1;
                    end
                end
                ST_UPD: begin
                    if (out_free) begin
                        r_calls <= r_calls + COUNT_BITS'(1);
                        if (!r_found) begin
                            r_misses <= r_misses + COUNT_BITS'(1);
                        end
                    end
                end
                ST_FRD: begin
                end
                ST_FEV: begin
                    if (fev_go) begin
                        if (rd.dirty) begin
                            r_pend_valid <= 1'b1;
                        end
                        if (r_idx != LAST_IDX) begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                ST_FEND: begin
                end
                default: begin
                end
            endcase

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_wr  <= (i_in_data.opcode == OP_WRITE);
            r_sec <= i_in_data.sector;
            r_now <= i_in_data.now_tick;
        end
        if (r_state == ST_SCAN && r_chk) begin
            // first matching valid entry serves the request
            if (match && !r_found) begin
                r_hit_idx   <= r_chk_idx;
                r_hit_dirty <= rd.dirty;
            end
            // strictly older stamp wins, so ties keep the lower index
            if (older) begin
                r_best_idx   <= r_chk_idx;
                r_best_stamp <= rd.stamp;
                r_vic_wb     <= rd.valid && rd.dirty;
                r_vic_sector <= rd.sector;
            end
        end
        if (r_state == ST_FEV && fev_go && rd.dirty) begin
            r_pend_idx    <= r_idx;
            r_pend_sector <= rd.sector;
        end
        if (emit) begin
            r_out <= emit_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/bclwt_chk.sv @@
// port level checker of the sector cache tag engine, bound to the top level
module bclwt_chk
    import bclwt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a hit needs neither fill nor write-back
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |->
            !o_out_data.fill_needed && !o_out_data.writeback_needed)
        else $error("hit result asks for fill or write-back");

    // no write-back means a zero sector
    a_wb_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.writeback_needed |->
            o_out_data.writeback_sector == '0)
        else $error("write-back sector set without write-back");

    // flush results carry cleared counters
    a_flush_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit && !o_out_data.fill_needed |->
            o_out_data.writeback_needed && o_out_data.call_count == '0 &&
            o_out_data.miss_count == '0)
        else $error("flush result with wrong flags or counts");

    // a real request keeps the engine busy on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.opcode != OP_NONE |=> o_in_stall)
        else $error("engine took a request without going busy");

endmodule

bind block_cache_lru_writeback_tags bclwt_chk u_bclwt_chk (.*);

@@ tb/block_cache_lru_writeback_tags_checker.sv @@
// watches both channels, predicts the tag engine results and compares them
`timescale 1ns / 100ps

module block_cache_lru_writeback_tags_checker
    import bclwt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    // shadow copy of the tag store and counters
    logic [SECTOR_BITS-1:0] tag_sector [ENTRIES_DEF];
    bit                     tag_valid  [ENTRIES_DEF];
    bit                     tag_dirty  [ENTRIES_DEF];
    logic [STAMP_BITS-1:0]  tag_stamp  [ENTRIES_DEF];
    logic [COUNT_BITS-1:0]  request_tally;
    logic [COUNT_BITS-1:0]  miss_tally;

    t_out_item awaited_lookups [$];
    t_out_item oldest;
    int        mismatch_count = 0;
    int        awaited_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = awaited_count;

    task automatic clear_tags();
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            tag_valid[i] = 1'b0;
            tag_dirty[i] = 1'b0;
            tag_stamp[i] = '0;
        end
        request_tally = '0;
        miss_tally    = '0;
    endtask

    // look up or flush, update the shadow store, queue the results
    task automatic resolve_request(input t_in_item req);
        int        found;
        int        victim;
        int        final_dirty;
        t_out_item res;
        case (req.opcode)
            OP_READ, OP_WRITE: begin
                found = -1;
                for (int i = 0; i < ENTRIES_DEF; i++)
                    if (found < 0 && tag_valid[i] && tag_sector[i] == req.sector)
                        found = i;
                request_tally = request_tally + 1'b1;
                res = '0;
                res.last = 1'b1;
                if (found >= 0) begin
                    tag_stamp[found] = req.now_tick;
                    if (req.opcode == OP_WRITE)
                        tag_dirty[found] = 1'b1;
                    res.slot = IDX_BITS'(found);
                    res.hit = 1'b1;
                end else begin
                    // oldest stamp wins, lowest index on ties, valid or not
                    victim = 0;
                    for (int i = 1; i < ENTRIES_DEF; i++)
                        if (tag_stamp[i] < tag_stamp[victim])
                            victim = i;
                    miss_tally = miss_tally + 1'b1;
                    res.slot = IDX_BITS'(victim);
                    res.fill_needed = 1'b1;
                    if (tag_valid[victim] && tag_dirty[victim]) begin
                        res.writeback_needed = 1'b1;
                        res.writeback_sector = tag_sector[victim];
                    end
                    tag_sector[victim] = req.sector;
                    tag_valid[victim]  = 1'b1;
                    tag_dirty[victim]  = (req.opcode == OP_WRITE);
                    tag_stamp[victim]  = req.now_tick;
                end
                res.call_count = request_tally;
                res.miss_count = miss_tally;
                awaited_lookups.push_back(res);
            end
            OP_FLUSH: begin
                request_tally = '0;
                miss_tally    = '0;
                final_dirty   = -1;
                for (int i = 0; i < ENTRIES_DEF; i++)
                    if (tag_dirty[i])
                        final_dirty = i;
                for (int i = 0; i < ENTRIES_DEF; i++) begin
                    if (tag_dirty[i]) begin
                        res = '0;
                        res.slot             = IDX_BITS'(i);
                        res.writeback_needed = 1'b1;
                        res.writeback_sector = tag_sector[i];
                        res.last             = (i == final_dirty);
                        res.call_count       = request_tally;
                        res.miss_count       = miss_tally;
                        awaited_lookups.push_back(res);
                    end
                    tag_dirty[i] = 1'b0;
                    tag_stamp[i] = req.now_tick;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tags();
            awaited_lookups.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_lookups.size() == 0) begin
                    $error("unexpected result item at slot %0d",
                           i_out_data.slot);
                    mismatch_count++;
                end else begin
                    oldest = awaited_lookups.pop_front();
                    compare_field("slot", 32'(oldest.slot),
                                  32'(i_out_data.slot));
                    compare_field("hit", 32'(oldest.hit), 32'(i_out_data.hit));
                    compare_field("fill_needed", 32'(oldest.fill_needed),
                                  32'(i_out_data.fill_needed));
                    compare_field("writeback_needed", 32'(oldest.writeback_needed),
                                  32'(i_out_data.writeback_needed));
                    compare_field("writeback_sector", 32'(oldest.writeback_sector),
                                  32'(i_out_data.writeback_sector));
                    compare_field("last", 32'(oldest.last), 32'(i_out_data.last));
                    compare_field("call_count", oldest.call_count,
                                  i_out_data.call_count);
                    compare_field("miss_count", oldest.miss_count,
                                  i_out_data.miss_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                resolve_request(i_in_data);
        end
        awaited_count = awaited_lookups.size();
    end

endmodule

@@ tb/block_cache_lru_writeback_tags_tb.sv @@
// stimulus and verdict for the lru write-back sector cache tag engine
`timescale 1ns / 100ps

module block_cache_lru_writeback_tags_tb;
    import bclwt_pkg::*;

    // worst case: every item a 64-result flush with long output stalls
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int ITEMS_PER_PHASE = 53;
    localparam int SECTOR_POOL     = 80;
    // idle plans per phase: none, sender idle, receiver stall, both lightly
    localparam int GAP_PLAN   [4] = '{0, 66, 0, 10};
    localparam int STALL_PLAN [4] = '{0, 0, 66, 10};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    int fail_count;
    int pending_count;
    int gap_pct   = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    // working set a little larger than the cache, so lru eviction and
    // dirty write-backs happen alongside plenty of hits
    logic [SECTOR_BITS-1:0] sector_pool [SECTOR_POOL];
    logic [STAMP_BITS-1:0]  tick_now = 32'd1000;
    t_in_item               next_req;

    block_cache_lru_writeback_tags DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    block_cache_lru_writeback_tags_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // consumer back-pressure, redrawn every falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("block_cache_lru_writeback_tags verification failed");
            $finish;
        end
    end

    function automatic t_in_item cache_req(input logic [1:0] op,
                                           input logic [SECTOR_BITS-1:0] sec,
                                           input logic [STAMP_BITS-1:0] tick);
        t_in_item it;
        it.opcode   = op;
        it.sector   = sec;
        it.now_tick = tick;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the accept
    task automatic push_request(input t_in_item it);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        // payload held until the engine stops stalling the input
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // sender holds off until every predicted result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    // mostly well-formed traffic on the working set with a slowly rising
    // tick; some noise: unused opcode, stray sectors, arbitrary ticks
    task automatic random_request(output t_in_item it);
        int roll;
        roll = $urandom_range(99);
        it.sector   = sector_pool[$urandom_range(SECTOR_POOL - 1)];
        it.now_tick = tick_now;
        tick_now    = tick_now + $urandom_range(3);
        if ($urandom_range(99) < 4)
            it.now_tick = $urandom;
        if (roll < 45) begin
            it.opcode = OP_READ;
        end else if (roll < 85) begin
            it.opcode = OP_WRITE;
        end else if (roll < 91) begin
            it.opcode = OP_FLUSH;
        end else if (roll < 94) begin
            it.opcode   = OP_NONE;
            it.sector   = SECTOR_BITS'($urandom);
            it.now_tick = $urandom;
        end else begin
            // request for a sector outside the working set
            it.opcode = $urandom_range(1) ? OP_WRITE : OP_READ;
            it.sector = SECTOR_BITS'($urandom);
        end
    endtask

    initial begin
        sector_pool[0] = '0;
        sector_pool[1] = '1;
        for (int i = 2; i < SECTOR_POOL; i++)
            sector_pool[i] = SECTOR_BITS'($urandom);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: flush of a clean cache gives nothing
        push_request(cache_req(OP_FLUSH, 23'h0, 32'h0));
        // tick zero keeps entry 0 the victim, so the second write evicts
        // the first dirty sector and must write it back
        push_request(cache_req(OP_WRITE, 23'h7FFFFF, 32'h0));
        push_request(cache_req(OP_WRITE, 23'h0, 32'h0));
        // read hit, then write hit on the same sector
        push_request(cache_req(OP_READ, 23'h0, 32'hFFFFFFFF));
        push_request(cache_req(OP_WRITE, 23'h0, 32'h7));
        // misses into never-used entries
        push_request(cache_req(OP_READ, 23'h555555, 32'h1));
        push_request(cache_req(OP_READ, 23'h2AAAAA, 32'h2));
        // unused opcode, all ones, must be ignored
        push_request(cache_req(OP_NONE, 23'h7FFFFF, 32'hFFFFFFFF));
        push_request(cache_req(OP_WRITE, 23'h2AAAAA, 32'h3));
        // flush with two dirty entries, then one with none left
        push_request(cache_req(OP_FLUSH, 23'h7FFFFF, 32'd100));
        push_request(cache_req(OP_FLUSH, 23'h0, 32'd200));
        // all stamps equal after a flush: lowest index is the victim
        push_request(cache_req(OP_READ, 23'h123456, 32'd50));
        push_request(cache_req(OP_READ, 23'h0, 32'd60));
        push_request(cache_req(OP_WRITE, 23'h7FFFFF, 32'd70));
        // flush with a single dirty entry, stamps restamped to all ones
        push_request(cache_req(OP_FLUSH, 23'h0, 32'hFFFFFFFF));
        push_request(cache_req(OP_READ, 23'h000001, 32'h0));
        push_request(cache_req(OP_WRITE, 23'h400000, 32'h80000000));
        drain_results();

        // random part, one phase per idle plan, drained between phases
        for (int phase = 0; phase < 4; phase++) begin
            gap_pct   = GAP_PLAN[phase];
            stall_pct = STALL_PLAN[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_request(next_req);
                push_request(next_req);
            end
            drain_results();
        end

        gap_pct   = 0;
        stall_pct = 0;
        // a trailing flush with nothing dirty may still be scanning
        repeat (2 * ENTRIES_DEF + 16) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("block_cache_lru_writeback_tags verification clean");
        end else begin
            $display("block_cache_lru_writeback_tags verification failed");
        end
        $finish;
    end

endmodule

@@ block_cache_lru_writeback_tags.f @@
rtl/bclwt_pkg.sv
rtl/bclwt_ram.sv
rtl/block_cache_lru_writeback_tags.sv
rtl/bclwt_chk.sv
tb/block_cache_lru_writeback_tags_checker.sv
tb/block_cache_lru_writeback_tags_tb.sv
